[rtl/sorted_timer_event_queue_top_macros.svh]
// assertion helpers for the timer queue
`ifndef SORTED_TIMER_EVENT_QUEUE_TOP_MACROS_SVH
`define SORTED_TIMER_EVENT_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define STQ_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define STQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`else

`define STQ_ASSERT(lbl, expr, msg)
`define STQ_ASSERT_SAME(lbl, ante, cons, msg)
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/stq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_BITS    = 8;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 32;
	localparam int DELAY_W     = 31;
	localparam int TAG_IO_W    = 8;
	localparam int KIND_W      = 3;
	localparam int OPCODE_W    = 2;

	typedef logic [TAG_BITS-1:0] tag_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_CHECK  = 2'd3
	} opcode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD     = 3'd0,
		KIND_REMOVE  = 3'd1,
		KIND_QUERY   = 3'd2,
		KIND_EXPIRED = 3'd3,
		KIND_DELAY   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_FIND,
		ST_CHECK
	} state_t;

	typedef enum logic [1:0] {
		SOP_NONE,
		SOP_INSERT,
		SOP_DELETE
	} store_op_t;

	typedef struct packed {
		store_op_t          op;
		logic [IDX_W-1:0]   pos;
		logic [TIME_W-1:0]  dl;
		tag_t               tag;
	} store_cmd_t;

	typedef struct packed {
		kind_t               kind;
		logic [TAG_IO_W-1:0] tag;
		logic                flag;
		logic                full;
		logic [DELAY_W-1:0]  delay;
		logic                last;
	} result_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] occ;
	} seq_status_t;

	function automatic tag_t tag_in(input logic [TAG_IO_W-1:0] t);
		tag_t r;
		r = '0;
		for (int i = 0; i < TAG_BITS; i++) begin
			if (i < TAG_IO_W) r[i] = t[i];
		end
		return r;
	endfunction

	function automatic logic [TAG_IO_W-1:0] tag_out(input tag_t t);
		logic [TAG_IO_W-1:0] r;
		r = '0;
		for (int i = 0; i < TAG_IO_W; i++) begin
			if (i < TAG_BITS) r[i] = t[i];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/sorted_timer_event_queue_top.sv]
// add, remove, query: one tag or deadline compare per cycle in the scan over the stored
//   entries; the result waits while the output slot is full
// check: one result per cycle unless the output stalls, one per expired event, then the delay
// next request is taken in the cycle after the last result is loaded
// reset clears occupancy, sequencer and output valid; entries are not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_timer_event_queue_top_macros.svh"
module sorted_timer_event_queue_top (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire logic [stq_pkg::OPCODE_W-1:0]  opcode,
	input  wire logic [stq_pkg::TAG_IO_W-1:0]  event_tag,
	input  wire logic [stq_pkg::TIME_W-1:0]    event_time,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [stq_pkg::KIND_W-1:0]         kind,
	output logic [stq_pkg::TAG_IO_W-1:0]       out_tag,
	output logic                               flag,
	output logic                               full_res,
	output logic [stq_pkg::DELAY_W-1:0]        delay,
	output logic                               last
);
	import stq_pkg::*;

	store_cmd_t        cmd;
	logic [IDX_W-1:0]  rd_idx;
	logic [TIME_W-1:0] rd_dl;
	tag_t              rd_tag;
	result_t           res;
	logic              res_load;
	logic              slot_free;
	seq_status_t       status;

	logic    out_valid_q;
	result_t res_q;

	stq_store u_store (
		.clk    (clk),
		.cmd    (cmd),
		.rd_idx (rd_idx),
		.rd_dl  (rd_dl),
		.rd_tag (rd_tag)
	);

	stq_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.event_tag  (event_tag),
		.event_time (event_time),
		.slot_free  (slot_free),
		.res_load   (res_load),
		.res        (res),
		.cmd        (cmd),
		.rd_idx     (rd_idx),
		.rd_dl      (rd_dl),
		.rd_tag     (rd_tag),
		.status     (status)
	);

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign kind      = res_q.kind;
	assign out_tag   = res_q.tag;
	assign flag      = res_q.flag;
	assign full_res  = res_q.full;
	assign delay     = res_q.delay;
	assign last      = res_q.last;

	`STQ_ASSERT(a_occ_bound, status.occ <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
	`STQ_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready right after request")
	`STQ_ASSERT_SAME(a_expired_busy, out_valid && (kind == KIND_EXPIRED), !in_ready, "idle during expiry")
	`STQ_ASSERT_SAME(a_ready_idle, in_ready, !status.busy, "ready while sequencer busy")

endmodule
`default_nettype wire

[rtl/stq_store.sv]
`timescale 1ns / 1ps
`default_nettype none
module stq_store (
	input  wire                                clk,
	input  wire stq_pkg::store_cmd_t           cmd,
	input  wire logic [stq_pkg::IDX_W-1:0]     rd_idx,
	output logic [stq_pkg::TIME_W-1:0]         rd_dl,
	output stq_pkg::tag_t                      rd_tag
);
	import stq_pkg::*;

	logic [TIME_W-1:0] dl_w [QUEUE_DEPTH];
	tag_t              tg_w [QUEUE_DEPTH];

	// each slot loads from its lower-index neighbor on insert, higher-index one on delete
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
		logic [TIME_W-1:0] dl_q;
		tag_t              tg_q;
		logic [TIME_W-1:0] prev_dl;
		tag_t              prev_tg;
		logic [TIME_W-1:0] next_dl;
		tag_t              next_tg;

		if (g == 0) begin : g_first
			assign prev_dl = cmd.dl;
			assign prev_tg = cmd.tag;
		end else begin : g_mid
			assign prev_dl = dl_w[g-1];
			assign prev_tg = tg_w[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_lastslot
			assign next_dl = dl_q;
			assign next_tg = tg_q;
		end else begin : g_inner
			assign next_dl = dl_w[g+1];
			assign next_tg = tg_w[g+1];
		end

		always_ff @(posedge clk) begin
			case (cmd.op)
				SOP_INSERT: begin
					if (IDX_W'(g) == cmd.pos) begin
						dl_q <= cmd.dl;
						tg_q <= cmd.tag;
					end else if (IDX_W'(g) > cmd.pos) begin
						dl_q <= prev_dl;
						tg_q <= prev_tg;
					end
				end
				SOP_DELETE: begin
					if (IDX_W'(g) >= cmd.pos) begin
						dl_q <= next_dl;
						tg_q <= next_tg;
					end
				end
				default: begin
				end
			endcase
		end

		assign dl_w[g] = dl_q;
		assign tg_w[g] = tg_q;
	end

	assign rd_dl  = dl_w[rd_idx];
	assign rd_tag = tg_w[rd_idx];

endmodule
`default_nettype wire

[rtl/stq_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
module stq_seq (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire logic [stq_pkg::OPCODE_W-1:0]   opcode,
	input  wire logic [stq_pkg::TAG_IO_W-1:0]   event_tag,
	input  wire logic [stq_pkg::TIME_W-1:0]     event_time,
	input  wire                                 slot_free,
	output logic                                res_load,
	output stq_pkg::result_t                    res,
	output stq_pkg::store_cmd_t                 cmd,
	output logic [stq_pkg::IDX_W-1:0]           rd_idx,
	input  wire logic [stq_pkg::TIME_W-1:0]     rd_dl,
	input  wire stq_pkg::tag_t                  rd_tag,
	output stq_pkg::seq_status_t                status
);
	import stq_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  occ_q, occ_d;
	opcode_t           op_q;
	tag_t              tag_q;
	logic [TIME_W-1:0] time_q;

	logic [TIME_W-1:0] diff;
	logic              later;
	logic              tag_hit;
	logic              at_end;

	// shared unit: wrap-aware deadline minus reference time
	assign diff    = rd_dl - time_q;
	assign later   = (diff != '0) && !diff[TIME_W-1];
	assign tag_hit = (rd_tag == tag_q);
	assign at_end  = (idx_q == occ_q);
	assign rd_idx  = idx_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			occ_q   <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= opcode_t'(opcode);
			tag_q  <= tag_in(event_tag);
			time_q <= event_time;
		end
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		occ_d     = occ_q;
		in_ready  = 1'b0;
		res_load  = 1'b0;
		cmd.op    = SOP_NONE;
		cmd.pos   = idx_q[IDX_W-1:0];
		cmd.dl    = time_q;
		cmd.tag   = tag_q;
		res.kind  = KIND_ADD;
		res.tag   = tag_out(tag_q);
		res.flag  = 1'b0;
		res.full  = 1'b0;
		res.delay = '0;
		res.last  = 1'b1;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					idx_d = '0;
					case (opcode_t'(opcode))
						OP_ADD:    state_d = ST_ADD;
						OP_REMOVE: state_d = ST_FIND;
						OP_QUERY:  state_d = ST_FIND;
						OP_CHECK:  state_d = ST_CHECK;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				res.kind = KIND_ADD;
				if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
					res.full = 1'b1;
					if (slot_free) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (at_end || later) begin
					// new entry goes after any equal deadlines
					res.flag = (idx_q == '0);
					if (slot_free) begin
						cmd.op   = SOP_INSERT;
						occ_d    = occ_q + 1'b1;
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_FIND: begin
				res.kind = (op_q == OP_REMOVE) ? KIND_REMOVE : KIND_QUERY;
				if (at_end) begin
					if (slot_free) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (tag_hit) begin
					res.flag = 1'b1;
					if (slot_free) begin
						if (op_q == OP_REMOVE) begin
							cmd.op = SOP_DELETE;
							occ_d  = occ_q - 1'b1;
						end
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_CHECK: begin
				// idx stays at the head throughout
				if (occ_q == '0 || later) begin
					res.kind = KIND_DELAY;
					res.tag  = '0;
					if (occ_q != '0) res.delay = diff[DELAY_W-1:0];
					if (slot_free) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					res.kind = KIND_EXPIRED;
					res.tag  = tag_out(rd_tag);
					res.last = 1'b0;
					if (slot_free) begin
						cmd.op   = SOP_DELETE;
						occ_d    = occ_q - 1'b1;
						res_load = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign status.busy = (state_q != ST_IDLE);
	assign status.occ  = occ_q;

endmodule
`default_nettype wire

[dv/sorted_timer_event_queue_top_tb.sv]
`timescale 1ns / 1ps
module sorted_timer_event_queue_top_tb;
	import stq_pkg::*;

	localparam int RANDOM_ITEMS = 480;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 40;
	localparam int CYCLE_LIMIT  = 400000;

	class event_queue_scoreboard;
		logic [TIME_W-1:0] dl_store [QUEUE_DEPTH];
		tag_t              tag_store [QUEUE_DEPTH];
		int                count;
		result_t           pending_replies [$];
		int                mismatches;

		function new();
			count = 0;
			mismatches = 0;
		endfunction

		// a comes after b when a - b is positive as a signed 32-bit value
		function bit is_after(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
			logic [TIME_W-1:0] d;
			d = a - b;
			return (d != '0) && !d[TIME_W-1];
		endfunction

		function void push_reply(kind_t k, logic [TAG_IO_W-1:0] tg, logic fl, logic fu,
			logic [DELAY_W-1:0] d, logic la);
			result_t r;
			r.kind = k;
			r.tag = tg;
			r.flag = fl;
			r.full = fu;
			r.delay = d;
			r.last = la;
			pending_replies.push_back(r);
		endfunction

		function int locate(tag_t tg);
			for (int i = 0; i < count; i++) begin
				if (tag_store[i] == tg) return i;
			end
			return -1;
		endfunction

		function void drop_at(int pos);
			for (int i = pos; i + 1 < count; i++) begin
				dl_store[i] = dl_store[i + 1];
				tag_store[i] = tag_store[i + 1];
			end
			count--;
		endfunction

		function void note_request(opcode_t op, logic [TAG_IO_W-1:0] tag_bits,
			logic [TIME_W-1:0] t);
			tag_t tg;
			logic [TAG_IO_W-1:0] echo;
			logic [TIME_W-1:0] d;
			int pos;
			tg = tag_t'(tag_bits);
			echo = tg;
			case (op)
				OP_ADD: begin
					if (count >= QUEUE_DEPTH) begin
						push_reply(KIND_ADD, echo, 1'b0, 1'b1, '0, 1'b1);
					end else begin
						// insert after any entries with an equal deadline
						pos = 0;
						while (pos < count && !is_after(dl_store[pos], t)) pos++;
						for (int i = count; i > pos; i--) begin
							dl_store[i] = dl_store[i - 1];
							tag_store[i] = tag_store[i - 1];
						end
						dl_store[pos] = t;
						tag_store[pos] = tg;
						count++;
						push_reply(KIND_ADD, echo, pos == 0, 1'b0, '0, 1'b1);
					end
				end
				OP_REMOVE: begin
					pos = locate(tg);
					if (pos >= 0) drop_at(pos);
					push_reply(KIND_REMOVE, echo, pos >= 0, 1'b0, '0, 1'b1);
				end
				OP_QUERY: begin
					pos = locate(tg);
					push_reply(KIND_QUERY, echo, pos >= 0, 1'b0, '0, 1'b1);
				end
				default: begin
					while (count > 0) begin
						d = dl_store[0] - t;
						if (d != '0 && !d[TIME_W-1]) begin
							push_reply(KIND_DELAY, '0, 1'b0, 1'b0, d[DELAY_W-1:0], 1'b1);
							return;
						end
						push_reply(KIND_EXPIRED, tag_store[0], 1'b0, 1'b0, '0, 1'b0);
						drop_at(0);
					end
					push_reply(KIND_DELAY, '0, 1'b0, 1'b0, '0, 1'b1);
				end
			endcase
		endfunction

		function bit same_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
				mismatches++;
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_reply(logic [KIND_W-1:0] k, logic [TAG_IO_W-1:0] tg, logic fl,
			logic fu, logic [DELAY_W-1:0] d, logic la);
			result_t e;
			if (pending_replies.size() == 0) begin
				$display("%0t unexpected reply expected none actual kind %0h tag %0h delay %0h",
					$time, k, tg, d);
				mismatches++;
				return;
			end
			e = pending_replies.pop_front();
			void'(same_field("kind", e.kind, k));
			void'(same_field("out_tag", e.tag, tg));
			void'(same_field("flag", e.flag, fl));
			void'(same_field("full_res", e.full, fu));
			void'(same_field("delay", e.delay, d));
			void'(same_field("last", e.last, la));
		endfunction

		function int outstanding();
			return pending_replies.size();
		endfunction

		function logic [TAG_IO_W-1:0] some_waiting_tag();
			if (count == 0) return TAG_IO_W'($urandom_range(0, 255));
			return tag_store[$urandom_range(0, count - 1)];
		endfunction

		function logic [TIME_W-1:0] head_deadline(logic [TIME_W-1:0] fallback);
			if (count == 0) return fallback;
			return dl_store[0];
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [OPCODE_W-1:0]  opcode;
	logic [TAG_IO_W-1:0]  event_tag;
	logic [TIME_W-1:0]    event_time;
	logic                 out_valid;
	logic                 out_ready;
	logic [KIND_W-1:0]    kind;
	logic [TAG_IO_W-1:0]  out_tag;
	logic                 flag;
	logic                 full_res;
	logic [DELAY_W-1:0]   delay;
	logic                 last;

	event_queue_scoreboard sb = new();
	bit                    hold_req;
	bit                    calm;
	int                    cycles;
	logic [TIME_W-1:0]     now;

	sorted_timer_event_queue_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.event_tag  (event_tag),
		.event_time (event_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_tag    (out_tag),
		.flag       (flag),
		.full_res   (full_res),
		.delay      (delay),
		.last       (last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_reply(kind, out_tag, flag, full_res, delay, last);
	end

	// receiver side, with one long hold-off so the block backs up
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = calm || ($urandom_range(0, 99) >= 11);
			end
		end
	end

	task automatic send_request(input opcode_t op, input logic [TAG_IO_W-1:0] tg,
		input logic [TIME_W-1:0] t);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 11) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		event_tag = tg;
		event_time = t;
		do @(posedge clk); while (!in_ready);
		sb.note_request(op, tg, t);
	endtask

	task automatic run_directed();
		logic [TIME_W-1:0] base;
		base = 32'hFFFF_FFF0;
		// check on an empty queue
		send_request(OP_CHECK, 8'h00, base);
		send_request(OP_ADD, 8'h00, base + 10);
		// equal deadline goes behind the first
		send_request(OP_ADD, 8'hFF, base + 10);
		send_request(OP_ADD, 8'h05, base);
		send_request(OP_ADD, 8'h05, base + 40);
		// deadlines spread across the 32-bit wrap
		for (int k = 0; k < 12; k++)
			send_request(OP_ADD, TAG_IO_W'(8'h10 + k), base + ((k * 13) % 60));
		send_request(OP_ADD, 8'hAA, base + 5);
		// duplicate tag: only the first from the head goes
		send_request(OP_REMOVE, 8'h05, 32'hFFFF_FFFF);
		send_request(OP_ADD, 8'h66, base + 20);
		send_request(OP_QUERY, 8'hFF, 32'h0000_0000);
		send_request(OP_REMOVE, 8'h77, 32'h5555_AAAA);
		// everything expires at once
		send_request(OP_CHECK, 8'h00, base + 200);
		now = base + 200;
		// half-range away reads as already past
		send_request(OP_ADD, 8'h31, now + 32'h8000_0000);
		send_request(OP_CHECK, 8'h00, now);
		send_request(OP_ADD, 8'h32, now + 32'h7FFF_FFFF);
		send_request(OP_CHECK, 8'h00, now);
	endtask

	task automatic run_random();
		int sel;
		int r;
		logic [TAG_IO_W-1:0] tg;
		logic [TIME_W-1:0] t;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100) hold_req = 1'b1;
			calm = (i >= 300 && i < 380);
			sel = $urandom_range(0, 99);
			r = $urandom_range(0, 9);
			if (sel < 4) begin
				send_request(opcode_t'($urandom_range(0, 3)), TAG_IO_W'($urandom_range(0, 255)),
					$urandom);
			end else if (sel < 46) begin
				tg = ($urandom_range(0, 9) < 7) ? TAG_IO_W'($urandom_range(0, 15))
					: TAG_IO_W'($urandom_range(0, 255));
				if (r < 6) t = now + $urandom_range(0, 300);
				else if (r < 8) t = now + $urandom_range(0, 5);
				else if (r == 8) t = now - $urandom_range(1, 50);
				else t = $urandom;
				send_request(OP_ADD, tg, t);
			end else if (sel < 72) begin
				tg = ($urandom_range(0, 2) > 0) ? sb.some_waiting_tag()
					: TAG_IO_W'($urandom_range(0, 255));
				send_request((sel < 59) ? OP_REMOVE : OP_QUERY, tg, $urandom);
			end else begin
				// time steps forward, jumps to a random value, or lands on the head deadline or just short of it
				if (r < 6) now = now + $urandom_range(0, 120);
				else if (r == 6) now = sb.head_deadline(now);
				else if (r == 7) now = sb.head_deadline(now) - 1;
				else if (r == 8) now = now + $urandom_range(0, 32'h7FFF_FFFF);
				else now = $urandom;
				send_request(OP_CHECK, TAG_IO_W'($urandom_range(0, 255)), now);
			end
		end
	endtask

	initial begin
		cycles = 0;
		hold_req = 1'b0;
		calm = 1'b0;
		now = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_ADD;
		event_tag = '0;
		event_time = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_directed();
		run_random();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.outstanding() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
